// ----- rtl/bmp_24bit_stream_writer_macros.svh -----
// ----------------------------------------------------------------------------
// BMP stream writer assertion macros
// Concurrent assertion shorthands, included by the back module of the writer.
// ----------------------------------------------------------------------------
`ifndef BMP_24BIT_STREAM_WRITER_MACROS_SVH
`define BMP_24BIT_STREAM_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Condition a implies condition c in the same cycle.
`define BMPW_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// Condition a implies condition c in the next cycle.
`define BMPW_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`else

`define BMPW_ASSERT_SAME(label, clk, rst_n, a, c)
`define BMPW_ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

// ----- rtl/bmpw_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP stream writer package
// Types, constants and the header byte table shared by the writer modules.
// ----------------------------------------------------------------------------
package bmpw_pkg;

	localparam int DIM_W           = 13;
	localparam int MAX_DIM_DEFAULT = 4096;
	localparam int QDEPTH          = 4;
	localparam int POS_W           = 6;
	localparam int CFG_IDX_W       = 1;
	localparam int ROW_BYTES_W     = 15;
	localparam int PROD_W          = 28;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	// Positions within the byte sequence of one item.
	localparam logic [POS_W-1:0] POS_BLUE  = 6'd54;
	localparam logic [POS_W-1:0] POS_GREEN = 6'd55;
	localparam logic [POS_W-1:0] POS_RED   = 6'd56;
	localparam logic [POS_W-1:0] POS_MAX   = 6'd59;

	localparam logic [31:0] HDR_BYTES   = 32'd54;
	localparam logic [31:0] DIB_BYTES   = 32'd40;
	localparam logic [31:0] PPM         = 32'd2835;
	localparam logic [15:0] BPP         = 16'd24;
	localparam logic [15:0] PLANES      = 16'd1;
	localparam logic [7:0]  CHAR_B      = 8'h42;
	localparam logic [7:0]  CHAR_M      = 8'h4D;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
	} out_item_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [31:0]      file_size;
	} dims_t;

	typedef struct packed {
		pixel_t     pix;
		logic       header;
		logic [1:0] pad;
		logic       frame_end;
	} q_entry_t;

	function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] sel);
		logic [7:0] b;
		case (sel)
			2'd0: b = v[7:0];
			2'd1: b = v[15:8];
			2'd2: b = v[23:16];
			2'd3: b = v[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Byte of the 54-byte file header at position pos.
	function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] pos, input dims_t d);
		logic [7:0]  b;
		logic [31:0] w32;
		logic [31:0] h32;
		w32 = 32'(d.width);
		h32 = 32'(d.height);
		case (pos)
			6'd0:  b = CHAR_B;
			6'd1:  b = CHAR_M;
			6'd2:  b = le_byte(d.file_size, 2'd0);
			6'd3:  b = le_byte(d.file_size, 2'd1);
			6'd4:  b = le_byte(d.file_size, 2'd2);
			6'd5:  b = le_byte(d.file_size, 2'd3);
			6'd10: b = le_byte(HDR_BYTES, 2'd0);
			6'd14: b = le_byte(DIB_BYTES, 2'd0);
			6'd18: b = le_byte(w32, 2'd0);
			6'd19: b = le_byte(w32, 2'd1);
			6'd20: b = le_byte(w32, 2'd2);
			6'd21: b = le_byte(w32, 2'd3);
			6'd22: b = le_byte(h32, 2'd0);
			6'd23: b = le_byte(h32, 2'd1);
			6'd24: b = le_byte(h32, 2'd2);
			6'd25: b = le_byte(h32, 2'd3);
			6'd26: b = PLANES[7:0];
			6'd27: b = PLANES[15:8];
			6'd28: b = BPP[7:0];
			6'd29: b = BPP[15:8];
			6'd38: b = le_byte(PPM, 2'd0);
			6'd39: b = le_byte(PPM, 2'd1);
			6'd42: b = le_byte(PPM, 2'd0);
			6'd43: b = le_byte(PPM, 2'd1);
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/bmp_24bit_stream_writer.sv -----
// An item accepted by an idle block is written into the queue, then its first byte into the output register.
// One output byte a cycle while out_stall is low; a pixel gives 3 bytes, plus 0 to 3
// bytes of row padding at the end of a row and 54 header bytes on the first pixel of a frame.
// The output byte sequencer sets the rate; a four-item queue absorbs bursts.
// Reset (arst_n low) clears the counters and queue; width and height return to 1.
// ----------------------------------------------------------------------------
// BMP 24-bit stream writer
// Turns a stream of RGB pixels into the byte stream of an uncompressed BMP file.
// ----------------------------------------------------------------------------
module bmp_24bit_stream_writer #(
	parameter int MAX_DIM = bmpw_pkg::MAX_DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bmpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmpw_pkg::DIM_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bmpw_pkg::pixel_t               pixel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bmpw_pkg::out_item_t            result
);
	import bmpw_pkg::*;

	dims_t    dims;
	q_entry_t wr_entry;
	q_entry_t head;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_valid;

	assign in_stall = q_full;

	bmpw_cfg #(
		.MAX_DIM(MAX_DIM)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.dims     (dims)
	);

	bmpw_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.pixel   (pixel),
		.q_full  (q_full),
		.dims    (dims),
		.push    (push),
		.entry   (wr_entry)
	);

	bmpw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.not_empty(q_valid),
		.full     (q_full)
	);

	bmpw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_valid  (q_valid),
		.dims     (dims),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result)
	);

endmodule

// ----- rtl/bmpw_cfg.sv -----
// ----------------------------------------------------------------------------
// BMP writer configuration
// Holds the dimension registers, clamps them and derives the file size.
// ----------------------------------------------------------------------------
module bmpw_cfg #(
	parameter int MAX_DIM = bmpw_pkg::MAX_DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bmpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmpw_pkg::DIM_W-1:0]     cfg_data,
	output bmpw_pkg::dims_t                dims
);
	import bmpw_pkg::*;

	localparam logic [31:0] MaxDim32 = 32'(MAX_DIM);

	logic [DIM_W-1:0]       width_q;
	logic [DIM_W-1:0]       height_q;
	logic [DIM_W-1:0]       width_eff;
	logic [DIM_W-1:0]       height_eff;
	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [31:0]            size_q;
	logic [PROD_W-1:0]      product;

	// Zero counts as one; values above the limit count as the limit.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MaxDim32) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign width_eff  = clamp_dim(width_q);
	assign height_eff = clamp_dim(height_q);

	// A row holds three bytes a pixel, padded to a multiple of four.
	assign product = PROD_W'(height_eff) * PROD_W'(row_bytes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_W'(4);
			size_q      <= 32'd58;
		end else begin
			row_bytes_q <= ROW_BYTES_W'({width_eff, 1'b0}) + ROW_BYTES_W'(width_eff)
				+ ROW_BYTES_W'(width_eff[1:0]);
			size_q      <= 32'(product) + HDR_BYTES;
		end
	end

	assign dims.width     = width_eff;
	assign dims.height    = height_eff;
	assign dims.file_size = size_q;

endmodule

// ----- rtl/bmpw_front.sv -----
// ----------------------------------------------------------------------------
// BMP writer front
// Accepts pixel items, tracks column and row, and tags each item with its
// header, padding and end-of-frame information.
// ----------------------------------------------------------------------------
module bmpw_front #(
	parameter int MAX_DIM = bmpw_pkg::MAX_DIM_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  bmpw_pkg::pixel_t   pixel,
	input  logic               q_full,
	input  bmpw_pkg::dims_t    dims,
	output logic               push,
	output bmpw_pkg::q_entry_t entry
);
	import bmpw_pkg::*;

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic             row_end;
	logic             frame_end;

	assign push      = in_valid && !q_full;
	assign row_end   = (32'(col_q) + 32'd1) >= 32'(dims.width);
	assign frame_end = row_end && ((32'(row_q) + 32'd1) >= 32'(dims.height));

	assign entry.pix       = pixel;
	assign entry.header    = (col_q == '0) && (row_q == '0);
	// Three bytes a pixel leave width mod 4 bytes of padding.
	assign entry.pad       = row_end ? dims.width[1:0] : 2'd0;
	assign entry.frame_end = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/bmpw_queue.sv -----
// ----------------------------------------------------------------------------
// BMP writer queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bmpw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bmpw_pkg::q_entry_t wr_entry,
	input  logic               pop,
	output bmpw_pkg::q_entry_t head,
	output logic               not_empty,
	output logic               full
);
	import bmpw_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	q_entry_t         slots_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(QDEPTH);
	assign not_empty = count_q != '0;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/bmpw_back.sv -----
// ----------------------------------------------------------------------------
// BMP writer back
// Walks the byte sequence of each queued item: header, pixel bytes and row
// padding, one byte a cycle into the output register while out_stall does not hold it.
// ----------------------------------------------------------------------------
module bmpw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmpw_pkg::q_entry_t   head,
	input  logic                 q_valid,
	input  bmpw_pkg::dims_t      dims,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bmpw_pkg::out_item_t  result
);
	import bmpw_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             started_q;
	logic [POS_W-1:0] cur_pos;
	logic [POS_W-1:0] last_pos;
	logic             is_last;
	logic             load;
	logic [7:0]       byte_val;
	logic             out_valid_q;
	out_item_t        out_q;

	// An item without header starts directly at its blue byte.
	assign cur_pos  = started_q ? pos_q : (head.header ? '0 : POS_BLUE);
	assign last_pos = POS_RED + POS_W'(head.pad);
	assign is_last  = cur_pos == last_pos;
	assign load     = !out_valid_q || !out_stall;
	assign pop      = load && q_valid && is_last;

	always_comb begin
		if (cur_pos < POS_BLUE) begin
			byte_val = hdr_byte(cur_pos, dims);
		end else if (cur_pos == POS_BLUE) begin
			byte_val = head.pix.blue;
		end else if (cur_pos == POS_GREEN) begin
			byte_val = head.pix.green;
		end else if (cur_pos == POS_RED) begin
			byte_val = head.pix.red;
		end else begin
			byte_val = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_valid;
			if (q_valid) begin
				started_q <= !is_last;
				pos_q     <= cur_pos + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			out_q.out_byte   <= byte_val;
			out_q.run_last   <= is_last;
			out_q.frame_done <= is_last && head.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

`include "bmp_24bit_stream_writer_macros.svh"

	`BMPW_ASSERT_SAME(a_done_is_last, clk, arst_n, out_valid_q && out_q.frame_done, out_q.run_last)
	`BMPW_ASSERT_SAME(a_pos_range, clk, arst_n, started_q, (pos_q != '0) && (pos_q <= POS_MAX))
	`BMPW_ASSERT_NEXT(a_pop_restarts, clk, arst_n, pop, !started_q && out_valid_q)

endmodule
